@@ sv/fcl_pkg.sv @@
// Package with the constants, types and result command format of the list parser.
`default_nettype none
package fcl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int WANT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = 4;
  localparam int TOTAL_W     = 5;
  localparam int CODE_W      = 32;
  localparam int LEN_W       = 16;
  localparam logic [LEN_W-1:0] CODE_LEN = LEN_W'(4);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_CODE   = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                 has_entry;
    logic [CODE_W-1:0]    code_word;
    logic [IDX_W-1:0]     entry_index;
    logic                 has_summary;
    logic [TOTAL_W-1:0]   entry_total;
    logic                 short_header;
  } fcl_cmd_t;

endpackage
`default_nettype wire

@@ sv/fcl_byte_if.sv @@
// Channel interfaces for the blob bytes and the parser results.
`default_nettype none
interface fcl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_blob;
  modport source (output valid, output data_byte, output end_of_blob, input ready);
  modport sink (input valid, input data_byte, input end_of_blob, output ready);
endinterface

interface fcl_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] code_word;
  logic [3:0]  entry_index;
  logic [4:0]  entry_total;
  logic        short_header;
  logic        final_result;
  modport source (output valid, output kind, output code_word, output entry_index,
                  output entry_total, output short_header, output final_result,
                  input ready);
  modport sink (input valid, input kind, input code_word, input entry_index,
                input entry_total, input short_header, input final_result,
                output ready);
endinterface
`default_nettype wire

@@ sv/fourcc_list_parser.sv @@
// Top level of the four-character-code list parser.
// The parser takes one blob byte per cycle on the blob channel and classifies it in the
// same cycle; a byte that completes an entry or ends the blob places a command in a
// four-deep queue, and the result stage turns each command into one or two results on
// the result channel. A byte that both completes an entry and ends the blob gives two
// results: the entry, then the summary. The blob channel stalls only while the queue is
// full, so the sustained rate is one byte per cycle as long as results are taken.
`default_nettype none
module fourcc_list_parser (
  input  wire logic    clk,
  input  wire logic    rst,
  fcl_byte_if.sink     blob,
  fcl_result_if.source result
);
  import fcl_pkg::*;

  fcl_cmd_t push_cmd;
  fcl_cmd_t head;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  fcl_front u_front (
    .clk  (clk),
    .rst  (rst),
    .blob (blob),
    .full (full),
    .push (push),
    .cmd  (push_cmd)
  );

  fcl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  fcl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("command popped from an empty queue");

  a_summary_follows_entry: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !result.kind && !result.final_result)
      |=> (result.valid && result.kind))
    else $error("entry without final mark not followed by its summary");

  a_summary_is_final: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind) |-> result.final_result)
    else $error("summary result without final mark");
endmodule
`default_nettype wire

@@ sv/fcl_front.sv @@
// Front end: takes blob bytes, tracks the parse state and issues result commands.
`default_nettype none
module fcl_front (
  input  wire logic      clk,
  input  wire logic      rst,
  fcl_byte_if.sink       blob,
  input  wire logic      full,
  output logic           push,
  output fcl_pkg::fcl_cmd_t cmd
);
  import fcl_pkg::*;

  phase_t              phase, phase_next;
  logic [1:0]          byte_position, byte_position_next;
  logic [WANT_W-1:0]   wanted_entries, wanted_entries_next;
  logic [WANT_W-1:0]   entries_done, entries_done_next;
  logic [23:0]         gather_register, gather_register_next;
  logic [7:0]          length_high, length_high_next;
  logic [CODE_W-1:0]   word;
  logic                accept;
  logic                emit_entry;

  assign blob.ready = !full;
  assign accept     = blob.valid && blob.ready;
  assign word       = {gather_register, blob.data_byte};

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    wanted_entries_next  = wanted_entries;
    entries_done_next    = entries_done;
    gather_register_next = gather_register;
    length_high_next     = length_high;
    emit_entry           = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        gather_register_next = word[23:0];
        byte_position_next   = byte_position + 2'd1;
        if (byte_position == 2'd3) begin
          wanted_entries_next  = (word > CODE_W'(MAX_ENTRIES)) ? WANT_W'(MAX_ENTRIES)
                                                              : word[WANT_W-1:0];
          gather_register_next = '0;
          phase_next = (wanted_entries_next != '0) ? PH_LENGTH : PH_IDLE;
        end
      end
      PH_LENGTH: begin
        if (byte_position == 2'd0) begin
          length_high_next   = blob.data_byte;
          byte_position_next = 2'd1;
        end else begin
          byte_position_next = 2'd0;
          phase_next = ({length_high, blob.data_byte} == CODE_LEN) ? PH_CODE : PH_IDLE;
        end
      end
      PH_CODE: begin
        gather_register_next = word[23:0];
        byte_position_next   = byte_position + 2'd1;
        if (byte_position == 2'd3) begin
          emit_entry           = 1'b1;
          entries_done_next    = entries_done + WANT_W'(1);
          gather_register_next = '0;
          phase_next = (entries_done_next < wanted_entries) ? PH_LENGTH : PH_IDLE;
        end
      end
      PH_IDLE: begin
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_comb begin
    cmd.has_entry    = emit_entry;
    cmd.code_word    = word;
    cmd.entry_index  = IDX_W'(entries_done);
    cmd.has_summary  = blob.end_of_blob;
    cmd.entry_total  = (phase_next == PH_HEADER) ? '0 : TOTAL_W'(entries_done_next);
    cmd.short_header = (phase_next == PH_HEADER);
  end

  assign push = accept && (emit_entry || blob.end_of_blob);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_position   <= '0;
      wanted_entries  <= '0;
      entries_done    <= '0;
      gather_register <= '0;
      length_high     <= '0;
    end else if (accept) begin
      if (blob.end_of_blob) begin
        phase           <= PH_HEADER;
        byte_position   <= '0;
        wanted_entries  <= '0;
        entries_done    <= '0;
        gather_register <= '0;
        length_high     <= '0;
      end else begin
        phase           <= phase_next;
        byte_position   <= byte_position_next;
        wanted_entries  <= wanted_entries_next;
        entries_done    <= entries_done_next;
        gather_register <= gather_register_next;
        length_high     <= length_high_next;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/fcl_queue.sv @@
// Short command queue between the parser front end and the result stage.
`default_nettype none
module fcl_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire fcl_pkg::fcl_cmd_t push_cmd,
  input  wire logic              pop,
  output logic                   full,
  output logic                   empty,
  output fcl_pkg::fcl_cmd_t      head
);
  import fcl_pkg::*;

  fcl_cmd_t            slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/fcl_back.sv @@
// Result stage: holds one command and sends its entry and summary results in order.
`default_nettype none
module fcl_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              empty,
  input  wire fcl_pkg::fcl_cmd_t head,
  output logic                   pop,
  fcl_result_if.source           result
);
  import fcl_pkg::*;

  fcl_cmd_t cur;
  logic     cur_valid;
  logic     xfer;
  logic     last_of_cur;
  logic     free;

  assign xfer        = result.valid && result.ready;
  assign last_of_cur = !(cur.has_entry && cur.has_summary);
  assign free        = !cur_valid || (xfer && last_of_cur);
  assign pop         = free && !empty;

  assign result.valid        = cur_valid;
  assign result.kind         = !cur.has_entry;
  assign result.code_word    = cur.has_entry ? cur.code_word : '0;
  assign result.entry_index  = cur.has_entry ? cur.entry_index : '0;
  assign result.entry_total  = cur.has_entry ? '0 : cur.entry_total;
  assign result.short_header = cur.has_entry ? 1'b0 : cur.short_header;
  assign result.final_result = cur.has_entry ? !cur.has_summary : 1'b1;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (xfer && !last_of_cur) begin
      cur.has_entry <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (free) begin
      cur_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ verif/tb_fourcc_list_parser.sv @@
// Self-checking testbench for the fourcc list parser: random blobs, random stalls, scoreboard.
module tb_fourcc_list_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import fcl_pkg::*;

  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam int   MAX_IDLE     = 13;
  localparam int   LONG_HOLD    = 150;
  localparam int   PHASE_BYTES  = 80;
  localparam int   MAX_PRINTED  = 40;

  typedef struct {
    logic [7:0] data_byte;
    logic       end_of_blob;
  } blob_byte_t;

  typedef struct {
    logic        kind;
    logic [31:0] code_word;
    logic [3:0]  entry_index;
    logic [4:0]  entry_total;
    logic        short_header;
    logic        final_result;
  } parse_result_t;

  logic clk;
  logic rst;

  fcl_byte_if   blob_ch();
  fcl_result_if res_ch();

  fourcc_list_parser dut (
    .clk    (clk),
    .rst    (rst),
    .blob   (blob_ch),
    .result (res_ch)
  );

  blob_byte_t    pending_bytes[$];
  parse_result_t expected_results[$];

  phase_t      parse_phase;
  logic [1:0]  parse_pos;
  int          entries_wanted;
  int          entries_parsed;
  logic [31:0] gather_word;
  logic [7:0]  length_msb;

  int   mismatches;
  int   results_seen;
  bit   tx_idle_on;
  bit   rx_idle_on;
  int   stall_asks;
  int   stall_done;
  int   hold_left;
  int   tx_wait;
  int   rx_wait;
  logic offering;
  logic taking;
  blob_byte_t offered;

  function automatic void clear_parse_state();
    parse_phase    = PH_HEADER;
    parse_pos      = 2'd0;
    entries_wanted = 0;
    entries_parsed = 0;
    gather_word    = '0;
    length_msb     = '0;
  endfunction

  function automatic void parse_byte(blob_byte_t b);
    logic [15:0]   length_word;
    parse_result_t r;
    case (parse_phase)
      PH_HEADER: begin
        gather_word = {gather_word[23:0], b.data_byte};
        parse_pos   = parse_pos + 2'd1;
        if (parse_pos == 2'd0) begin
          entries_wanted = (gather_word > 32'(MAX_ENTRIES)) ? MAX_ENTRIES : int'(gather_word);
          gather_word    = '0;
          parse_phase    = (entries_wanted != 0) ? PH_LENGTH : PH_IDLE;
        end
      end
      PH_LENGTH: begin
        if (parse_pos == 2'd0) begin
          length_msb = b.data_byte;
          parse_pos  = 2'd1;
        end else begin
          length_word = {length_msb, b.data_byte};
          parse_pos   = 2'd0;
          parse_phase = (length_word == 16'd4) ? PH_CODE : PH_IDLE;
        end
      end
      PH_CODE: begin
        gather_word = {gather_word[23:0], b.data_byte};
        parse_pos   = parse_pos + 2'd1;
        if (parse_pos == 2'd0) begin
          r.kind         = KIND_ENTRY;
          r.code_word    = gather_word;
          r.entry_index  = 4'(entries_parsed);
          r.entry_total  = '0;
          r.short_header = 1'b0;
          r.final_result = !b.end_of_blob;
          expected_results.push_back(r);
          entries_parsed++;
          gather_word = '0;
          parse_phase = (entries_parsed < entries_wanted) ? PH_LENGTH : PH_IDLE;
        end
      end
      default: ;
    endcase
    if (b.end_of_blob) begin
      r.kind         = KIND_SUMMARY;
      r.code_word    = '0;
      r.entry_index  = '0;
      r.short_header = (parse_phase == PH_HEADER);
      r.entry_total  = r.short_header ? 5'd0 : 5'(entries_parsed);
      r.final_result = 1'b1;
      expected_results.push_back(r);
      clear_parse_state();
    end
  endfunction

  task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("result %0d: %s is %0h, expected %0h", results_seen, field, got, want);
  endtask

  function automatic void push_byte(logic [7:0] data, logic last);
    blob_byte_t b;
    b.data_byte   = data;
    b.end_of_blob = last;
    pending_bytes.push_back(b);
  endfunction

  function automatic int queue_random_blob();
    logic [7:0]  bytes[$];
    logic [31:0] count;
    logic [15:0] length_word;
    int          entries;
    int          sel;
    int          keep;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 8)) bytes.push_back(8'($urandom));
    end else begin
      if (sel < 13) count = '0;
      else if (sel < 20) count = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(17, 20));
      else if (sel < 28) count = 32'($urandom_range(6, MAX_ENTRIES));
      else count = 32'($urandom_range(1, 5));
      entries = (count > 32'(MAX_ENTRIES)) ? MAX_ENTRIES + 1 : int'(count);
      for (int i = 3; i >= 0; i--) bytes.push_back(count[8*i +: 8]);
      for (int e = 0; e < entries; e++) begin
        length_word = 16'd4;
        if ($urandom_range(0, 11) == 0) begin
          length_word = 16'($urandom);
          if (length_word == 16'd4) length_word = 16'd5;
        end
        bytes.push_back(length_word[15:8]);
        bytes.push_back(length_word[7:0]);
        repeat (4) bytes.push_back(8'($urandom));
      end
      repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        keep = $urandom_range(1, bytes.size());
        while (bytes.size() > keep) void'(bytes.pop_back());
      end
    end
    foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1);
    return bytes.size();
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || offering || expected_results.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      blob_ch.valid <= 1'b0;
      offering = 1'b0;
      tx_wait = 0;
    end else begin
      if (blob_ch.valid && blob_ch.ready) begin
        parse_byte(offered);
        offering = 1'b0;
        tx_wait = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (!offering) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_bytes.size() > 0) begin
          offered = pending_bytes.pop_front();
          offering = 1'b1;
          blob_ch.data_byte <= offered.data_byte;
          blob_ch.end_of_blob <= offered.end_of_blob;
        end
      end
      blob_ch.valid <= offering;
    end
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected transfer, kind", 32'(res_ch.kind), '0);
        end else begin
          want = expected_results.pop_front();
          if (res_ch.kind !== want.kind)
            note_mismatch("kind", 32'(res_ch.kind), 32'(want.kind));
          if (res_ch.code_word !== want.code_word)
            note_mismatch("code_word", res_ch.code_word, want.code_word);
          if (res_ch.entry_index !== want.entry_index)
            note_mismatch("entry_index", 32'(res_ch.entry_index), 32'(want.entry_index));
          if (res_ch.entry_total !== want.entry_total)
            note_mismatch("entry_total", 32'(res_ch.entry_total), 32'(want.entry_total));
          if (res_ch.short_header !== want.short_header)
            note_mismatch("short_header", 32'(res_ch.short_header), 32'(want.short_header));
          if (res_ch.final_result !== want.final_result)
            note_mismatch("final_result", 32'(res_ch.final_result), 32'(want.final_result));
        end
        rx_wait = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall_done != stall_asks) begin
        stall_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        taking = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        taking = 1'b0;
      end else begin
        taking = 1'b1;
      end
      res_ch.ready <= taking;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    blob_ch.valid = 1'b0;
    blob_ch.data_byte = '0;
    blob_ch.end_of_blob = 1'b0;
    res_ch.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int queued;
    mismatches = 0;
    results_seen = 0;
    stall_asks = 0;
    stall_done = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    clear_parse_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Short headers, an empty list, an entry that ends the blob, and a bad length.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hAB, 1'b0); push_byte(8'hCD, 1'b1);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h04, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h04, 1'b1);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      tx_idle_on = p[0];
      rx_idle_on = p[1];
      queued = 0;
      while (queued < PHASE_BYTES) queued += queue_random_blob();
      // The sender streams without gaps here, so the long hold backs up the parser.
      if (p == 0) stall_asks++;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ fourcc_list_parser.f @@
sv/fcl_pkg.sv
sv/fcl_byte_if.sv
sv/fcl_front.sv
sv/fcl_queue.sv
sv/fcl_back.sv
sv/fourcc_list_parser.sv
verif/tb_fourcc_list_parser.sv
